// ===== rtl/core/afu_pkg.sv =====
package afu_pkg;

    // Default number of fraction bits of the fixed-point format
    localparam int FRAC_BITS_DEF = 16;

    // Activation kinds
    typedef enum logic [1:0] {
        KIND_LINEAR  = 2'd0,
        KIND_RELU    = 2'd1,
        KIND_SIGMOID = 2'd2,
        KIND_TANH    = 2'd3
    } t_kind;

    // Configuration register indexes
    localparam logic [1:0] CFG_KIND    = 2'd0;
    localparam logic [1:0] CFG_SIG_LO  = 2'd1;
    localparam logic [1:0] CFG_SIG_HI  = 2'd2;
    localparam logic [1:0] CFG_EXP_LIM = 2'd3;

    // Reset values of the clamp registers
    localparam logic signed [31:0] SIG_LO_RST  = -32'sd2621440;
    localparam logic signed [31:0] SIG_HI_RST  = 32'sd851968;
    localparam logic signed [31:0] EXP_LIM_RST = 32'sd2621440;

    // exp constants: log2(e) in Q24, ln(2) in Q30, reciprocal of three in Q30
    localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [28:0] DIV3_M    = 29'd357913942;

    // 2^(i/4) in Q30
    localparam logic [30:0] POW2_QTR [4] = '{
        31'd1073741824, 31'd1276901417, 31'd1518500249, 31'd1805811301
    };

    // Largest value that exp gives
    localparam logic [62:0] EXP_CAP = 63'd1 << 62;

    // Stage control that travels with each request
    typedef struct packed {
        logic               vld;
        logic               div;
        logic               tanh;
        logic               gmul;
        logic signed [31:0] val;
    } t_ctl;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
        if (v > 96'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -96'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== rtl/core/activation_function_unit.sv =====
// Scalar activation unit in signed fixed point with FRAC_BITS fraction bits. The
// activation_kind register picks linear, relu, sigmoid or tanh; a request with
// req_type 0 gives the activation of value_a, with req_type 1 the gradient from the
// incoming gradient value_a and the forward output value_b. Every request gives one
// result. The unit takes one request per cycle while the output is not stalled.
// Eleven stages form the clamp, the gradient product, the exp argument split, the
// Horner polynomial, the table scaling, the power-of-two scaling and the divider
// operands; FRAC_BITS+2 stages of a restoring divider then take one quotient bit
// apiece, and an output register follows. A stall on the output freezes the whole
// pipeline. Write configuration only while no request is in flight.
module activation_function_unit #(
    parameter int FRAC_BITS = afu_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_req_type,
    input  logic signed [31:0] i_value_a,
    input  logic signed [31:0] i_value_b,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_value
);

    localparam int XW   = FRAC_BITS + 8;
    localparam int AW   = (XW > 34) ? XW : 34;
    localparam int YW   = XW + 26;
    localparam int NDIV = FRAC_BITS + 2;
    localparam int DW   = 64 + NDIV;
    localparam int NCTL = 11 + NDIV;

    localparam logic signed [AW-1:0] X_LIM =
        {{(AW-FRAC_BITS-7){1'b0}}, 1'b1, {(FRAC_BITS+6){1'b0}}};
    localparam logic signed [32:0] ONE33 = {{(32-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [NDIV-1:0] Q_MAX = {2'b10, {FRAC_BITS{1'b0}}};

    // Configuration registers
    afu_pkg::t_kind     r_kind;
    logic signed [31:0] r_sig_lo;
    logic signed [31:0] r_sig_hi;
    logic signed [31:0] r_exp_lim;

    // Pipeline advance
    logic w_adv;

    // Stage registers
    afu_pkg::t_ctl        r_ctl [NCTL];
    logic signed [XW-1:0] r_s1_x;
    logic signed [64:0]   r_s1_gp;
    logic signed [31:0]   r_s1_g;
    logic signed [YW-1:0] r_s2_y;
    logic signed [31:0]   r_s2_c;
    logic signed [31:0]   r_s2_g;
    logic [27:0]          r_s3_r;
    logic signed [63:0]   r_s3_gc;
    logic signed [7:0]    r_pipe_n [3:9];
    logic [1:0]           r_pipe_idx [3:8];
    logic [27:0]          r_pipe_t [4:7];
    logic [58:0]          r_s5_p;
    logic [57:0]          r_s6_d;
    logic [58:0]          r_s7_p;
    logic [58:0]          r_s8_p;
    logic [61:0]          r_s9_p;
    logic [62:0]          r_s10_e;
    logic [63:0]          r_s11_rem;
    logic [63:0]          r_s11_den;
    logic [63:0]          r_div_rem [NDIV];
    logic [63:0]          r_div_den [NDIV];
    logic [NDIV-1:0]      r_div_q   [NDIV];
    logic                 r_out_vld;
    logic signed [31:0]   r_out_val;

    // Next values
    afu_pkg::t_ctl        n_ctl0;
    afu_pkg::t_ctl        n_ctl3;
    logic signed [31:0]   w_sig_t;
    logic signed [AW-1:0] w_m2;
    logic signed [AW-1:0] w_arg;
    logic signed [AW-1:0] w_argc;
    logic signed [32:0]   w_omy;
    logic signed [64:0]   n_s1_gp;
    logic signed [64:0]   w_sh;
    logic signed [31:0]   n_s2_c;
    logic [YW-1:0]        w_uy;
    logic [7:0]           w_nb;
    logic [57:0]          w_tprod;
    logic [30:0]          w_q1;
    logic [30:0]          w_q2;
    logic [30:0]          w_q3;
    logic [30:0]          w_q4;
    logic [31:0]          w_p;
    logic signed [8:0]    w_s;
    logic signed [8:0]    w_sneg;
    logic [62:0]          n_s10_e;
    logic [63:0]          w_den;
    logic [63:0]          w_num;
    logic [63:0]          n_div_rem [NDIV];
    logic [NDIV-1:0]      n_div_q   [NDIV];
    logic signed [31:0]   n_out_val;

    assign w_adv   = !(r_out_vld && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_out_vld;
    assign o_result_value = r_out_val;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= afu_pkg::KIND_LINEAR;
            r_sig_lo  <= afu_pkg::SIG_LO_RST;
            r_sig_hi  <= afu_pkg::SIG_HI_RST;
            r_exp_lim <= afu_pkg::EXP_LIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                afu_pkg::CFG_KIND:    r_kind    <= afu_pkg::t_kind'(i_cfg_wdata[1:0]);
                afu_pkg::CFG_SIG_LO:  r_sig_lo  <= i_cfg_wdata;
                afu_pkg::CFG_SIG_HI:  r_sig_hi  <= i_cfg_wdata;
                afu_pkg::CFG_EXP_LIM: r_exp_lim <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage 1: clamp the exp argument, pick direct results, start gradient product
    always_comb begin
        w_sig_t = (i_value_a < r_sig_lo) ? r_sig_lo : i_value_a;
        if (w_sig_t > r_sig_hi) begin
            w_sig_t = r_sig_hi;
        end
        w_m2 = -(AW'(i_value_a) <<< 1);
        case (r_kind)
            afu_pkg::KIND_SIGMOID: w_arg = -AW'(w_sig_t);
            afu_pkg::KIND_TANH:    w_arg = (w_m2 > AW'(r_exp_lim)) ? AW'(r_exp_lim) : w_m2;
            default:               w_arg = '0;
        endcase
        if (w_arg > X_LIM) begin
            w_argc = X_LIM;
        end else if (w_arg < -X_LIM) begin
            w_argc = -X_LIM;
        end else begin
            w_argc = w_arg;
        end

        w_omy = ONE33 - 33'(i_value_b);
        if (r_kind == afu_pkg::KIND_TANH) begin
            n_s1_gp = i_value_b * i_value_b;
        end else begin
            n_s1_gp = i_value_b * w_omy;
        end

        n_ctl0.vld  = i_valid;
        n_ctl0.tanh = (r_kind == afu_pkg::KIND_TANH);
        n_ctl0.div  = 1'b0;
        n_ctl0.gmul = 1'b0;
        n_ctl0.val  = '0;
        if (!i_req_type) begin
            case (r_kind)
                afu_pkg::KIND_RELU: n_ctl0.val = (i_value_a > 0) ? i_value_a : '0;
                afu_pkg::KIND_SIGMOID,
                afu_pkg::KIND_TANH: n_ctl0.div = 1'b1;
                default:            n_ctl0.val = i_value_a;
            endcase
        end else begin
            case (r_kind)
                afu_pkg::KIND_RELU: n_ctl0.val = (i_value_b > 0) ? i_value_a : '0;
                afu_pkg::KIND_SIGMOID,
                afu_pkg::KIND_TANH: n_ctl0.gmul = 1'b1;
                default:            n_ctl0.val = i_value_a;
            endcase
        end
    end

    // Stage 2: saturated gradient factor
    always_comb begin
        w_sh = r_s1_gp >>> FRAC_BITS;
        if (r_kind == afu_pkg::KIND_TANH) begin
            n_s2_c = afu_pkg::sat32(96'(ONE33) - 96'(w_sh));
        end else begin
            n_s2_c = afu_pkg::sat32(96'(w_sh));
        end
    end

    // Stage 3: split the base-2 exponent into integer, quarter index and remainder
    always_comb begin
        w_uy = YW'(r_s2_y) + (YW'(1) << (FRAC_BITS + 31));
        w_nb = w_uy[FRAC_BITS+31:FRAC_BITS+24];
    end

    // Stage 4: final gradient; stages 5 to 9: Horner terms and table scaling
    always_comb begin
        n_ctl3 = r_ctl[2];
        if (r_ctl[2].gmul) begin
            n_ctl3.val = afu_pkg::sat32(96'(r_s3_gc >>> FRAC_BITS));
        end
        w_tprod = r_s3_r * afu_pkg::LN2_Q30;
        w_q1    = 31'(1 << 30) + 31'(r_pipe_t[4] >> 2);
        w_q2    = 31'(1 << 30) + 31'(r_s6_d[57:30]);
        w_q3    = 31'(1 << 30) + 31'(r_s7_p[58:31]);
        w_q4    = 31'(1 << 30) + 31'(r_s8_p[58:30]);
    end

    // Stage 10: scale by the integer power of two, cap and flush
    always_comb begin
        w_p    = r_s9_p[61:30];
        w_s    = 9'(r_pipe_n[9]) + 9'(FRAC_BITS - 30);
        w_sneg = -w_s;
        if (w_s > 9'sd31) begin
            n_s10_e = afu_pkg::EXP_CAP;
        end else if (w_s >= 9'sd0) begin
            n_s10_e = 63'(64'(w_p) << w_s[4:0]);
        end else if (w_s < -9'sd40) begin
            n_s10_e = '0;
        end else begin
            n_s10_e = 63'(64'(w_p) >> w_sneg[5:0]);
        end
    end

    // Stage 11: denominator and rounded dividend
    always_comb begin
        w_den = (64'(1) << FRAC_BITS) + 64'(r_s10_e);
        w_num = r_ctl[9].tanh ? (64'(1) << (2 * FRAC_BITS + 1)) : (64'(1) << (2 * FRAC_BITS));
    end

    // Divider: one quotient bit per stage, most significant first
    for (genvar gk = 0; gk < NDIV; gk++) begin : g_div
        logic [63:0]     w_src_rem;
        logic [63:0]     w_src_den;
        logic [NDIV-1:0] w_src_q;
        logic [DW-1:0]   w_cmp;
        logic [DW-1:0]   w_dsh;
        if (gk == 0) begin : g_first
            assign w_src_rem = r_s11_rem;
            assign w_src_den = r_s11_den;
            assign w_src_q   = '0;
        end else begin : g_next
            assign w_src_rem = r_div_rem[gk-1];
            assign w_src_den = r_div_den[gk-1];
            assign w_src_q   = r_div_q[gk-1];
        end
        always_comb begin
            w_cmp = DW'(w_src_rem);
            w_dsh = DW'(w_src_den) << (NDIV - 1 - gk);
            if (w_cmp >= w_dsh) begin
                n_div_rem[gk] = 64'(w_cmp - w_dsh);
                n_div_q[gk]   = {w_src_q[NDIV-2:0], 1'b1};
            end else begin
                n_div_rem[gk] = w_src_rem;
                n_div_q[gk]   = {w_src_q[NDIV-2:0], 1'b0};
            end
        end
    end

    // Output: quotient, shifted quotient for tanh, or the direct value
    always_comb begin
        if (!r_ctl[NCTL-1].div) begin
            n_out_val = r_ctl[NCTL-1].val;
        end else if (r_ctl[NCTL-1].tanh) begin
            n_out_val = 32'(r_div_q[NDIV-1]) - 32'(ONE33);
        end else begin
            n_out_val = 32'(r_div_q[NDIV-1]);
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NCTL; k++) begin
                r_ctl[k].vld <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_ctl[0] <= n_ctl0;
            for (int k = 1; k < NCTL; k++) begin
                if (k == 3) begin
                    r_ctl[k] <= n_ctl3;
                end else begin
                    r_ctl[k] <= r_ctl[k-1];
                end
            end
            r_out_vld <= r_ctl[NCTL-1].vld;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_x  <= w_argc[XW-1:0];
            r_s1_gp <= n_s1_gp;
            r_s1_g  <= i_value_a;

            r_s2_y <= r_s1_x * $signed({1'b0, afu_pkg::LOG2E_Q24});
            r_s2_c <= n_s2_c;
            r_s2_g <= r_s1_g;

            r_pipe_n[3]   <= $signed({~w_nb[7], w_nb[6:0]});
            r_pipe_idx[3] <= w_uy[FRAC_BITS+23:FRAC_BITS+22];
            r_s3_r        <= w_uy[FRAC_BITS+21:FRAC_BITS-6];
            r_s3_gc       <= r_s2_g * r_s2_c;

            for (int k = 4; k <= 9; k++) begin
                r_pipe_n[k] <= r_pipe_n[k-1];
            end
            for (int k = 4; k <= 8; k++) begin
                r_pipe_idx[k] <= r_pipe_idx[k-1];
            end
            r_pipe_t[4] <= w_tprod[57:30];
            for (int k = 5; k <= 7; k++) begin
                r_pipe_t[k] <= r_pipe_t[k-1];
            end

            r_s5_p  <= r_pipe_t[4] * w_q1;
            r_s6_d  <= r_s5_p[58:30] * afu_pkg::DIV3_M;
            r_s7_p  <= r_pipe_t[6] * w_q2;
            r_s8_p  <= r_pipe_t[7] * w_q3;
            r_s9_p  <= afu_pkg::POW2_QTR[r_pipe_idx[8]] * w_q4;
            r_s10_e <= n_s10_e;

            r_s11_den <= w_den;
            r_s11_rem <= w_num + (w_den >> 1);

            for (int k = 0; k < NDIV; k++) begin
                r_div_rem[k] <= n_div_rem[k];
                r_div_q[k]   <= n_div_q[k];
            end
            r_div_den[0] <= r_s11_den;
            for (int k = 1; k < NDIV; k++) begin
                r_div_den[k] <= r_div_den[k-1];
            end

            r_out_val <= n_out_val;
        end
    end

    // A taken request occupies the first stage next cycle
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_ctl[0].vld)
        else $error("taken request lost at pipeline entry");

    // exp never exceeds its cap
    a_exp_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[9].vld |-> (r_s10_e <= afu_pkg::EXP_CAP))
        else $error("exp result above cap");

    // Quotient of a sigmoid or tanh never exceeds two
    a_quot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl[NCTL-1].vld && r_ctl[NCTL-1].div) |-> (r_div_q[NDIV-1] <= Q_MAX))
        else $error("divider quotient out of range");

endmodule
